>>> hdl/bed_pkg.sv
// Shared types, character constants and helpers for the backslash escape decoder.
// No dependencies.
package bed_pkg;

    localparam int RUN_MAX = 4;
    localparam int IDX_W   = 2;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_V      = 8'h76;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_ESC = 8'h1B;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESC    = 5'b00010,
        MODE_OCT    = 5'b00100,
        MODE_HEX1   = 5'b01000,
        MODE_HEX2   = 5'b10000
    } mode_t;

    // One decoded run: up to four bytes caused by one input transaction.
    typedef struct packed {
        logic [IDX_W-1:0]       last_idx;
        logic [RUN_MAX-1:0][7:0] data;
    } run_t;

    typedef struct packed {
        logic valid;
        run_t run;
    } slot_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_nib(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

>>> hdl/bed_front.sv
// Front end: holds the escape enable and decode state, turns each accepted
// transaction into a run of output bytes. Depends on bed_pkg.
module bed_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          is_end,
    output bed_pkg::slot_t push
);
    import bed_pkg::*;

    logic        enable_reg;
    mode_t       mode_reg, mode_next;
    logic [8:0]  oval_reg, oval_next;
    logic [1:0]  ocnt_reg, ocnt_next;
    logic [7:0]  held_reg, held_next;

    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]  n;
    logic        do_fresh;
    logic [4:0]  hx, hh;
    logic [8:0]  oacc;
    logic [1:0]  ocnt_inc;
    logic        is_oct;

    always_comb begin
        mode_next = mode_reg;
        oval_next = oval_reg;
        ocnt_next = ocnt_reg;
        held_next = held_reg;
        bytes     = '0;
        n         = 3'd0;
        do_fresh  = 1'b0;
        hx        = hex_nib(in_byte);
        hh        = hex_nib(held_reg);
        oacc      = {oval_reg[5:0], in_byte[2:0]};
        ocnt_inc  = ocnt_reg + 2'd1;
        is_oct    = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_SEVEN);

        if (is_end) begin
            unique case (mode_reg)
                MODE_ESC: begin
                    bytes[n[1:0]] = CHAR_BSLASH; n = n + 3'd1;
                end
                MODE_OCT: begin
                    if (ocnt_reg != 2'd0) begin
                        bytes[n[1:0]] = oval_reg[7:0]; n = n + 3'd1;
                    end
                end
                MODE_HEX1: begin
                    bytes[n[1:0]] = CHAR_BSLASH; n = n + 3'd1;
                    bytes[n[1:0]] = CHAR_X;      n = n + 3'd1;
                end
                MODE_HEX2: begin
                    bytes[n[1:0]] = CHAR_BSLASH; n = n + 3'd1;
                    bytes[n[1:0]] = CHAR_X;      n = n + 3'd1;
                    bytes[n[1:0]] = held_reg;    n = n + 3'd1;
                end
                default: ;
            endcase
            mode_next = MODE_NORMAL;
            oval_next = '0;
            ocnt_next = '0;
        end else begin
            unique case (mode_reg)
                MODE_ESC: begin
                    mode_next = MODE_NORMAL;
                    unique case (in_byte)
                        CHAR_A:      begin bytes[0] = CTL_BEL; n = 3'd1; end
                        CHAR_B:      begin bytes[0] = CTL_BS;  n = 3'd1; end
                        CHAR_E:      begin bytes[0] = CTL_ESC; n = 3'd1; end
                        CHAR_F:      begin bytes[0] = CTL_FF;  n = 3'd1; end
                        CHAR_N:      begin bytes[0] = CTL_LF;  n = 3'd1; end
                        CHAR_R:      begin bytes[0] = CTL_CR;  n = 3'd1; end
                        CHAR_T:      begin bytes[0] = CTL_TAB; n = 3'd1; end
                        CHAR_V:      begin bytes[0] = CTL_VT;  n = 3'd1; end
                        CHAR_BSLASH: begin bytes[0] = CHAR_BSLASH; n = 3'd1; end
                        CHAR_ZERO: begin
                            mode_next = MODE_OCT;
                            oval_next = '0;
                            ocnt_next = '0;
                        end
                        CHAR_X:      mode_next = MODE_HEX1;
                        default: begin
                            bytes[0] = CHAR_BSLASH;
                            bytes[1] = in_byte;
                            n = 3'd2;
                        end
                    endcase
                end
                MODE_OCT: begin
                    if (is_oct) begin
                        oval_next = oacc;
                        ocnt_next = ocnt_inc;
                        if (ocnt_inc == 2'd3) begin
                            bytes[0]  = oacc[7:0]; n = 3'd1;
                            mode_next = MODE_NORMAL;
                            oval_next = '0;
                            ocnt_next = '0;
                        end
                    end else begin
                        if (ocnt_reg != 2'd0) begin
                            bytes[n[1:0]] = oval_reg[7:0]; n = n + 3'd1;
                        end
                        oval_next = '0;
                        ocnt_next = '0;
                        do_fresh  = 1'b1;
                    end
                end
                MODE_HEX1: begin
                    if (hx[4]) begin
                        held_next = in_byte;
                        mode_next = MODE_HEX2;
                    end else begin
                        bytes[n[1:0]] = CHAR_BSLASH; n = n + 3'd1;
                        bytes[n[1:0]] = CHAR_X;      n = n + 3'd1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_HEX2: begin
                    if (hx[4]) begin
                        bytes[0]  = {(hh[4] ? hh[3:0] : 4'd0), hx[3:0]}; n = 3'd1;
                        mode_next = MODE_NORMAL;
                    end else begin
                        bytes[n[1:0]] = CHAR_BSLASH; n = n + 3'd1;
                        bytes[n[1:0]] = CHAR_X;      n = n + 3'd1;
                        bytes[n[1:0]] = held_reg;    n = n + 3'd1;
                        do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            if (do_fresh) begin
                if (in_byte == CHAR_BSLASH && enable_reg) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_NORMAL;
                    bytes[n[1:0]] = in_byte; n = n + 3'd1;
                end
            end
        end
    end

    assign push.valid        = accept && (n != 3'd0);
    assign push.run.data     = bytes;
    assign push.run.last_idx = IDX_W'(n - 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            mode_reg   <= MODE_NORMAL;
            oval_reg   <= '0;
            ocnt_reg   <= '0;
            held_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (accept) begin
                mode_reg <= mode_next;
                oval_reg <= oval_next;
                ocnt_reg <= ocnt_next;
                held_reg <= held_next;
            end
        end
    end

endmodule

>>> hdl/bed_queue.sv
// Short FIFO of decoded runs between the front end and the output serializer.
// Depends on bed_pkg.
module bed_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bed_pkg::slot_t push,
    input  logic           pop,
    output bed_pkg::slot_t head,
    output logic           full
);
    import bed_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    run_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.run   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push.valid && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push.valid && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/bed_back.sv
// Output serializer: walks the head run one byte per cycle, while m_ready
// does not stall it, into the output register. Depends on bed_pkg.
module bed_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  bed_pkg::slot_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_of_run
);
    import bed_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_last;

    assign load    = !valid_reg || m_ready;
    assign at_last = (idx_reg == head.run.last_idx);
    assign pop     = load && head.valid && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = head.valid;
            byte_next  = head.run.data[idx_reg];
            last_next  = at_last;
            if (head.valid) begin
                idx_next = at_last ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

>>> hdl/backslash_escape_decoder.sv
// Backslash escape decoder top level: front end, run queue and output serializer.
// Depends on bed_pkg, bed_front, bed_queue, bed_back.
//
// The block accepts one input transaction per cycle while its run queue
// (QUEUE_DEPTH entries) has room. Each transaction is decoded in the cycle it
// is accepted into a run of zero to four bytes; the output serializer sends
// one byte per cycle while m_ready does not stall it, so a stream of items
// with one result each sustains one byte per cycle. Items that give no result
// (an opening backslash, a held digit, an end marker with nothing pending)
// put nothing on the output. The first output byte of a run passes through
// the run queue storage and then the serializer output register. The escape
// enable register may be written at any edge through cfg_wr_en.
module backslash_escape_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);
    import bed_pkg::*;

    slot_t push;
    slot_t head;
    logic  pop;
    logic  full;
    logic  accept;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    bed_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_byte     (s_in_byte),
        .is_end      (s_is_end),
        .push        (push)
    );

    bed_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (full)
    );

    bed_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> hdl/bed_checker.sv
// Port-level checks for the backslash escape decoder, bound to the top level.
// Depends on backslash_escape_decoder.
module bed_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_of_run
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_last_of_run (m_last_of_run)
);

>>> tb/backslash_escape_decoder_tb.sv
// Testbench for backslash_escape_decoder: directed escape cases, then random text
// under three idle patterns, checked against a behavioral decoder. Depends on bed_pkg and backslash_escape_decoder.
module backslash_escape_decoder_tb;
    import bed_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_is_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    // decoder state kept alongside the block
    logic       esc_enable = 1'b0;
    mode_t      dec_mode = MODE_NORMAL;
    logic [8:0] oct_val = 9'd0;
    logic [1:0] oct_cnt = 2'd0;
    logic [7:0] held_hex = 8'h00;
    logic [7:0] run_bytes[$];

    out_beat_t  expected_beats[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         text_bytes_sent = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    logic [7:0] simple_escapes[9] = '{CHAR_A, CHAR_B, CHAR_E, CHAR_F, CHAR_N,
                                      CHAR_R, CHAR_T, CHAR_V, CHAR_BSLASH};

    backslash_escape_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_is_end      (s_is_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= 8'h39) begin
            return int'(c - CHAR_ZERO);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return int'(c - 8'h61) + 10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return int'(c - 8'h41) + 10;
        end
        return -1;
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        dec_mode = MODE_NORMAL;
        if (c == CHAR_BSLASH && esc_enable) begin
            dec_mode = MODE_ESC;
        end else begin
            run_bytes.push_back(c);
        end
    endfunction

    function automatic void escaped_byte(input logic [7:0] c);
        dec_mode = MODE_NORMAL;
        case (c)
            CHAR_A:      run_bytes.push_back(CTL_BEL);
            CHAR_B:      run_bytes.push_back(CTL_BS);
            CHAR_E:      run_bytes.push_back(CTL_ESC);
            CHAR_F:      run_bytes.push_back(CTL_FF);
            CHAR_N:      run_bytes.push_back(CTL_LF);
            CHAR_R:      run_bytes.push_back(CTL_CR);
            CHAR_T:      run_bytes.push_back(CTL_TAB);
            CHAR_V:      run_bytes.push_back(CTL_VT);
            CHAR_BSLASH: run_bytes.push_back(CHAR_BSLASH);
            CHAR_ZERO: begin
                dec_mode = MODE_OCT;
                oct_val = 9'd0;
                oct_cnt = 2'd0;
            end
            CHAR_X:      dec_mode = MODE_HEX1;
            default: begin
                run_bytes.push_back(CHAR_BSLASH);
                run_bytes.push_back(c);
            end
        endcase
    endfunction

    // Decode one accepted transaction and queue the bytes it produces.
    function automatic void decode_item(input logic [7:0] c, input logic is_end);
        int hi;
        int lo;
        run_bytes = {};
        if (is_end) begin
            case (dec_mode)
                MODE_ESC: run_bytes.push_back(CHAR_BSLASH);
                MODE_OCT: begin
                    if (oct_cnt != 0) run_bytes.push_back(oct_val[7:0]);
                end
                MODE_HEX1: begin
                    run_bytes.push_back(CHAR_BSLASH);
                    run_bytes.push_back(CHAR_X);
                end
                MODE_HEX2: begin
                    run_bytes.push_back(CHAR_BSLASH);
                    run_bytes.push_back(CHAR_X);
                    run_bytes.push_back(held_hex);
                end
                default: ;
            endcase
            dec_mode = MODE_NORMAL;
            oct_val = 9'd0;
            oct_cnt = 2'd0;
        end else begin
            case (dec_mode)
                MODE_ESC: escaped_byte(c);
                MODE_OCT: begin
                    if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                        oct_val = {oct_val[5:0], c[2:0]};
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3) begin
                            run_bytes.push_back(oct_val[7:0]);
                            dec_mode = MODE_NORMAL;
                            oct_val = 9'd0;
                            oct_cnt = 2'd0;
                        end
                    end else begin
                        if (oct_cnt != 0) run_bytes.push_back(oct_val[7:0]);
                        oct_val = 9'd0;
                        oct_cnt = 2'd0;
                        plain_byte(c);
                    end
                end
                MODE_HEX1: begin
                    if (hex_value(c) >= 0) begin
                        held_hex = c;
                        dec_mode = MODE_HEX2;
                    end else begin
                        run_bytes.push_back(CHAR_BSLASH);
                        run_bytes.push_back(CHAR_X);
                        plain_byte(c);
                    end
                end
                MODE_HEX2: begin
                    lo = hex_value(c);
                    if (lo >= 0) begin
                        hi = hex_value(held_hex);
                        run_bytes.push_back({hi[3:0], lo[3:0]});
                        dec_mode = MODE_NORMAL;
                    end else begin
                        run_bytes.push_back(CHAR_BSLASH);
                        run_bytes.push_back(CHAR_X);
                        run_bytes.push_back(held_hex);
                        plain_byte(c);
                    end
                end
                default: plain_byte(c);
            endcase
        end
        foreach (run_bytes[i]) begin
            expected_beats.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
        end
    endfunction

    // Output checks first, then input transactions, then register writes.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                             $time, m_out_byte, m_last_of_run);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (m_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, m_out_byte);
                        error_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last, m_last_of_run);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) decode_item(s_in_byte, s_is_end);
            if (cfg_wr_en) esc_enable = cfg_wr_data;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [7:0] c, input logic is_end);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_in_byte <= c;
        s_is_end  <= is_end;
        do @(posedge aclk); while (!s_ready);
        if (!is_end) text_bytes_sent++;
    endtask

    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_escape_enable(input logic value);
        settle_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(2))
            0:       return CHAR_ZERO + 8'($urandom_range(9));
            1:       return 8'h61 + 8'($urandom_range(5));
            default: return 8'h41 + 8'($urandom_range(5));
        endcase
    endfunction

    task automatic test_passthrough();
        write_escape_enable(1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_escape_cases();
        write_escape_enable(1'b1);
        // escaped byte with no meaning keeps its backslash
        send_item(CHAR_BSLASH, 1'b0);
        send_item(8'hFF, 1'b0);
        // three octal digits, value wraps to 8 bits
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_ZERO, 1'b0);
        send_item(CHAR_SEVEN, 1'b0);
        send_item(CHAR_SEVEN, 1'b0);
        send_item(CHAR_SEVEN, 1'b0);
        // octal cut short by a backslash that opens a hex escape
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_ZERO, 1'b0);
        send_item(8'h35, 1'b0);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_X, 1'b0);
        send_item(CHAR_F, 1'b0);
        send_item(8'h46, 1'b0);
        // bad second hex digit
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_X, 1'b0);
        send_item(8'h31, 1'b0);
        send_item(8'h67, 1'b0);
        // bad first hex digit, then end with a held hex digit, in octal mode and after a backslash
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_X, 1'b0);
        send_item(8'h47, 1'b0);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_X, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_ZERO, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_enable_mid_escape();
        write_escape_enable(1'b1);
        send_item(CHAR_BSLASH, 1'b0);
        write_escape_enable(1'b0);
        send_item(CHAR_X, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h31, 1'b0);
        send_item(CHAR_BSLASH, 1'b0);
        send_item(CHAR_N, 1'b0);
    endtask

    task automatic test_random_text(input int count, input logic enable,
                                    input int send_pct, input int recv_pct);
        int stop_at;
        int kind;
        int digits;
        write_escape_enable(enable);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = text_bytes_sent + count;
        while (text_bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                send_item(8'($urandom_range(255)), 1'b0);
            end else if (kind < 45) begin
                send_item(CHAR_BSLASH, 1'b0);
                send_item(simple_escapes[$urandom_range(8)], 1'b0);
            end else if (kind < 53) begin
                send_item(CHAR_BSLASH, 1'b0);
                send_item(8'($urandom_range(255)), 1'b0);
            end else if (kind < 68) begin
                send_item(CHAR_BSLASH, 1'b0);
                send_item(CHAR_ZERO, 1'b0);
                digits = $urandom_range(4);
                repeat (digits) send_item(CHAR_ZERO + 8'($urandom_range(7)), 1'b0);
            end else if (kind < 87) begin
                send_item(CHAR_BSLASH, 1'b0);
                send_item(CHAR_X, 1'b0);
                send_item(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_hex_char(),
                          1'b0);
                send_item(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_hex_char(),
                          1'b0);
            end else if (kind < 94) begin
                send_item(8'($urandom_range(255)), 1'b1);
            end else begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 24;
        recv_idle_pct = 59;
        test_passthrough();
        test_escape_cases();
        test_enable_mid_escape();
        test_random_text(120, 1'b1, 24, 59);
        test_random_text(30, 1'b0, 59, 24);
        test_random_text(90, 1'b1, 59, 24);
        test_random_text(70, 1'b1, 0, 0);
        send_item(8'h00, 1'b1);
        settle_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
